>>> design/sars_pkg.sv
`default_nettype none

package sars_pkg;

   // Fixed field widths
   localparam int MODULE_BITS  = 5;
   localparam int CHAN_W       = 5;
   localparam int LINE_BITS    = 3;
   localparam int SAMPLE_BITS  = 12;
   localparam int COUNT_BITS   = 4;
   localparam int EXP_BITS     = 3;

   // Defaults for the top level parameters
   localparam int DATA_BITS_DEF    = 12;
   localparam int CHANNEL_BITS_DEF = 5;
   localparam int MAX_MODULE_DEF   = 16;

   // Module number map boundaries
   localparam logic [MODULE_BITS-1:0] MOD_LAST_SHARED = 5'd1;
   localparam logic [MODULE_BITS-1:0] MOD_LAST_PORT1  = 5'd4;
   localparam logic [MODULE_BITS-1:0] MOD_LAST_PORT2  = 5'd8;
   localparam logic [MODULE_BITS-1:0] MOD_FIRST_EXP   = 5'd9;
   localparam logic [LINE_BITS-1:0]   EXP_LINE        = 3'd7;
   localparam logic                   PORT_1          = 1'b0;
   localparam logic                   PORT_2          = 1'b1;

   // Last bit index of the expander and lead pulse loops
   localparam logic [COUNT_BITS-1:0]  EXP_LAST        = 4'd2;
   localparam logic [COUNT_BITS-1:0]  LEAD_LAST       = 4'd1;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_START   = 1'b1;

   // Sequencer phases
   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_EXP_HI  = 8'b0000_0010,
      PH_EXP_LO  = 8'b0000_0100,
      PH_LEAD_HI = 8'b0000_1000,
      PH_LEAD_LO = 8'b0001_0000,
      PH_DATA_HI = 8'b0010_0000,
      PH_DATA_LO = 8'b0100_0000,
      PH_RELEASE = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic                   command;
      logic [MODULE_BITS-1:0] module_req;
      logic [CHAN_W-1:0]      channel;
      logic                   sdi;
   } req_payload_type;

   typedef struct packed {
      logic                   sclk;
      logic                   sdo;
      logic [LINE_BITS-1:0]   select_line;
      logic                   select_port;
      logic                   select_asserted;
      logic                   busy_res;
      logic                   sample_valid;
      logic [SAMPLE_BITS-1:0] sample;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> design/serial_adc_read_sequencer.sv
// Serial converter read sequencer, master side.
// Each request word is one pin phase step: command advance moves the read
// sequence on by one phase, command start (taken only while idle) latches a
// module number and a channel code and drops that module's select line.
// Every request word gives exactly one response word holding the pin levels
// after that step (sclk, sdo, select line/port, select asserted), busy, and on
// the release step sample_valid with the twelve-bit sample.
// A read is: start, three expander select bits for modules 9 and up, two lead
// clock pulses, the data bits MSB first, then release - one word per phase.
// Latency: a response word is registered and appears in the cycle after its request is accepted.
// Throughput: one word per cycle unless the receiver stalls; the next-state logic is a single pass from
// the state registers to the response register.
// req_ready is high whenever the response register is empty or being taken,
// so a stalled receiver holds the response and stops new requests only then.
// Reset (synchronous, active high) returns the sequencer to idle with select
// line 0 on port 1, clock and data-out low, and empties the response register.
`default_nettype none

module serial_adc_read_sequencer #(
   parameter int DATA_BITS    = sars_pkg::DATA_BITS_DEF,
   parameter int CHANNEL_BITS = sars_pkg::CHANNEL_BITS_DEF,
   parameter int MAX_MODULE   = sars_pkg::MAX_MODULE_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  sars_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output sars_pkg::rsp_payload_type rsp_data
);

   localparam int CW = sars_pkg::COUNT_BITS;
   localparam int SW = sars_pkg::SAMPLE_BITS;
   localparam int MW = sars_pkg::MODULE_BITS;

   // State
   sars_pkg::phase_type             phase_ff, phase_in;
   logic [CW-1:0]                   bit_count_ff, bit_count_in;
   logic [SW-1:0]                   sample_ff, sample_in;
   logic [sars_pkg::CHAN_W-1:0]     channel_ff, channel_in;
   logic [sars_pkg::EXP_BITS-1:0]   exp_code_ff, exp_code_in;
   logic [sars_pkg::LINE_BITS-1:0]  line_ff, line_in;
   logic                            port_ff, port_in;
   logic                            clock_lvl_ff, clock_lvl_in;
   logic                            dout_lvl_ff, dout_lvl_in;

   logic                            rsp_valid_ff;
   sars_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic                            selected;
   logic                            done;
   logic [MW-1:0]                   module_sat;
   logic [MW-1:0]                   module_m1;
   logic [MW-1:0]                   module_m9;
   logic [1:0]                      exp_idx;
   logic                            chan_drive;
   logic                            last_bit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Step helpers
   assign module_sat = (req_data.module_req > MW'(MAX_MODULE)) ?
                       MW'(MAX_MODULE) : req_data.module_req;
   assign module_m1  = module_sat - MW'(1);
   assign module_m9  = module_sat - sars_pkg::MOD_FIRST_EXP;
   assign exp_idx    = 2'd2 - bit_count_ff[1:0];
   assign chan_drive = ({2'b00, bit_count_ff} + 6'(CHANNEL_BITS)) >= 6'(DATA_BITS);
   assign last_bit   = ({1'b0, bit_count_ff} + 5'd1) >= 5'(DATA_BITS);

   // Phase sequencer next state
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      sample_in    = sample_ff;
      channel_in   = channel_ff;
      exp_code_in  = exp_code_ff;
      line_in      = line_ff;
      port_in      = port_ff;
      clock_lvl_in = clock_lvl_ff;
      dout_lvl_in  = dout_lvl_ff;
      selected     = 1'b1;
      done         = 1'b0;

      unique case (phase_ff)
         sars_pkg::PH_EXP_HI: begin
            dout_lvl_in  = exp_code_ff[exp_idx];
            clock_lvl_in = 1'b1;
            phase_in     = sars_pkg::PH_EXP_LO;
         end
         sars_pkg::PH_EXP_LO: begin
            clock_lvl_in = 1'b0;
            if (bit_count_ff >= sars_pkg::EXP_LAST) begin
               bit_count_in = '0;
               phase_in     = sars_pkg::PH_LEAD_HI;
            end else begin
               bit_count_in = bit_count_ff + CW'(1);
               phase_in     = sars_pkg::PH_EXP_HI;
            end
         end
         sars_pkg::PH_LEAD_HI: begin
            clock_lvl_in = 1'b1;
            phase_in     = sars_pkg::PH_LEAD_LO;
         end
         sars_pkg::PH_LEAD_LO: begin
            clock_lvl_in = 1'b0;
            if (bit_count_ff >= sars_pkg::LEAD_LAST) begin
               bit_count_in = '0;
               phase_in     = sars_pkg::PH_DATA_HI;
            end else begin
               bit_count_in = bit_count_ff + CW'(1);
               phase_in     = sars_pkg::PH_LEAD_HI;
            end
         end
         sars_pkg::PH_DATA_HI: begin
            sample_in = {sample_ff[SW-2:0], req_data.sdi};
            // channel goes out LSB first on the last channel bits
            if (chan_drive) begin
               dout_lvl_in = channel_ff[0];
               channel_in  = channel_ff >> 1;
            end
            clock_lvl_in = 1'b1;
            phase_in     = sars_pkg::PH_DATA_LO;
         end
         sars_pkg::PH_DATA_LO: begin
            clock_lvl_in = 1'b0;
            if (last_bit) begin
               bit_count_in = '0;
               phase_in     = sars_pkg::PH_RELEASE;
            end else begin
               bit_count_in = bit_count_ff + CW'(1);
               phase_in     = sars_pkg::PH_DATA_HI;
            end
         end
         sars_pkg::PH_RELEASE: begin
            selected = 1'b0;
            done     = 1'b1;
            phase_in = sars_pkg::PH_IDLE;
         end
         default: begin
            phase_in = sars_pkg::PH_IDLE;
            selected = 1'b0;
            if (req_data.command == sars_pkg::CMD_START) begin
               // module number to select line and port
               exp_code_in = '0;
               if (module_sat <= sars_pkg::MOD_LAST_SHARED) begin
                  line_in = '0;
                  port_in = sars_pkg::PORT_1;
               end else if (module_sat <= sars_pkg::MOD_LAST_PORT1) begin
                  line_in = module_m1[sars_pkg::LINE_BITS-1:0];
                  port_in = sars_pkg::PORT_1;
               end else if (module_sat <= sars_pkg::MOD_LAST_PORT2) begin
                  line_in = module_m1[sars_pkg::LINE_BITS-1:0];
                  port_in = sars_pkg::PORT_2;
               end else begin
                  line_in     = sars_pkg::EXP_LINE;
                  port_in     = sars_pkg::PORT_2;
                  exp_code_in = module_m9[sars_pkg::EXP_BITS-1:0];
               end
               channel_in   = req_data.channel;
               sample_in    = '0;
               bit_count_in = '0;
               clock_lvl_in = 1'b0;
               selected     = 1'b1;
               phase_in     = (module_sat >= sars_pkg::MOD_FIRST_EXP) ?
                              sars_pkg::PH_EXP_HI : sars_pkg::PH_LEAD_HI;
            end
         end
      endcase
   end

   // Response word
   always_comb begin
      rsp_data_in.sclk            = clock_lvl_in;
      rsp_data_in.sdo             = dout_lvl_in;
      rsp_data_in.select_line     = line_in;
      rsp_data_in.select_port     = port_in;
      rsp_data_in.select_asserted = selected;
      rsp_data_in.busy_res        = (phase_in != sars_pkg::PH_IDLE);
      rsp_data_in.sample_valid    = done;
      rsp_data_in.sample          = done ? sample_ff : '0;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sars_pkg::PH_IDLE;
         bit_count_ff <= '0;
         sample_ff    <= '0;
         channel_ff   <= '0;
         exp_code_ff  <= '0;
         line_ff      <= '0;
         port_ff      <= sars_pkg::PORT_1;
         clock_lvl_ff <= 1'b0;
         dout_lvl_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         sample_ff    <= sample_in;
         channel_ff   <= channel_in;
         exp_code_ff  <= exp_code_in;
         line_ff      <= line_in;
         port_ff      <= port_in;
         clock_lvl_ff <= clock_lvl_in;
         dout_lvl_ff  <= dout_lvl_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sars_checker.sv
`default_nettype none

module sars_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input sars_pkg::req_payload_type req_data,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input sars_pkg::rsp_payload_type rsp_data
);

   // Stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // Empty response register always takes a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // Select is asserted exactly while a read is running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.select_asserted == rsp_data.busy_res)
      else $error("select and busy disagree");

   // Sample shows only on the release step, which ends the read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sample_valid |-> rsp_data.sample == '0)
      else $error("sample nonzero without sample_valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_valid |-> !rsp_data.busy_res && !rsp_data.sclk)
      else $error("release step while busy or clock high");

endmodule

bind serial_adc_read_sequencer sars_checker u_sars_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/serial_adc_read_sequencer_tb.sv
`timescale 1ns / 1ps

module serial_adc_read_sequencer_tb;

   localparam int DATA_BITS    = sars_pkg::DATA_BITS_DEF;
   localparam int CHANNEL_BITS = sars_pkg::CHANNEL_BITS_DEF;
   localparam int MAX_MODULE   = sars_pkg::MAX_MODULE_DEF;
   localparam int RANDOM_ITEMS = 1150;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   sars_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   sars_pkg::rsp_payload_type rsp_data;

   serial_adc_read_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Words waiting to be sent, and the pin levels each accepted word should give
   sars_pkg::req_payload_type pending_words[$];
   sars_pkg::rsp_payload_type expected_levels[$];
   int              total_words;
   int              accepted_count = 0;
   int              err_count = 0;

   // Predicted sequencer state
   sars_pkg::phase_type pin_phase;
   logic [3:0]       pin_count;
   logic [15:0]      sample_sr;
   logic [4:0]       chan_sr;
   logic [2:0]       exp_code;
   logic [2:0]       sel_line;
   logic             sel_port;
   logic             clk_lvl;
   logic             sdo_lvl;

   task automatic clear_pin_state();
      pin_phase = sars_pkg::PH_IDLE;
      pin_count = '0;
      sample_sr = '0;
      chan_sr   = '0;
      exp_code  = '0;
      sel_line  = '0;
      sel_port  = sars_pkg::PORT_1;
      clk_lvl   = 1'b0;
      sdo_lvl   = 1'b0;
   endtask

   // One pin phase step; returns the levels shown after it
   function automatic sars_pkg::rsp_payload_type step_pins(sars_pkg::req_payload_type w);
      sars_pkg::rsp_payload_type lv;
      logic            selected;
      logic            done;
      logic [4:0]      m;
      selected = 1'b1;
      done     = 1'b0;
      lv       = '0;
      case (pin_phase)
         sars_pkg::PH_EXP_HI: begin
            sdo_lvl   = exp_code[2'(2'd2 - pin_count[1:0])];
            clk_lvl   = 1'b1;
            pin_phase = sars_pkg::PH_EXP_LO;
         end
         sars_pkg::PH_EXP_LO: begin
            clk_lvl = 1'b0;
            if (pin_count >= sars_pkg::EXP_LAST) begin
               pin_count = '0;
               pin_phase = sars_pkg::PH_LEAD_HI;
            end else begin
               pin_count++;
               pin_phase = sars_pkg::PH_EXP_HI;
            end
         end
         sars_pkg::PH_LEAD_HI: begin
            clk_lvl   = 1'b1;
            pin_phase = sars_pkg::PH_LEAD_LO;
         end
         sars_pkg::PH_LEAD_LO: begin
            clk_lvl = 1'b0;
            if (pin_count >= sars_pkg::LEAD_LAST) begin
               pin_count = '0;
               pin_phase = sars_pkg::PH_DATA_HI;
            end else begin
               pin_count++;
               pin_phase = sars_pkg::PH_LEAD_HI;
            end
         end
         sars_pkg::PH_DATA_HI: begin
            sample_sr = {sample_sr[14:0], w.sdi};
            // channel goes out LSB first during the last data bits
            if (int'(pin_count) + CHANNEL_BITS >= DATA_BITS) begin
               sdo_lvl = chan_sr[0];
               chan_sr = chan_sr >> 1;
            end
            clk_lvl   = 1'b1;
            pin_phase = sars_pkg::PH_DATA_LO;
         end
         sars_pkg::PH_DATA_LO: begin
            clk_lvl = 1'b0;
            if (int'(pin_count) + 1 >= DATA_BITS) begin
               pin_count = '0;
               pin_phase = sars_pkg::PH_RELEASE;
            end else begin
               pin_count++;
               pin_phase = sars_pkg::PH_DATA_HI;
            end
         end
         sars_pkg::PH_RELEASE: begin
            selected  = 1'b0;
            done      = 1'b1;
            pin_phase = sars_pkg::PH_IDLE;
         end
         default: begin
            pin_phase = sars_pkg::PH_IDLE;
            selected  = 1'b0;
            if (w.command == sars_pkg::CMD_START) begin
               m = (w.module_req > MAX_MODULE) ? 5'(MAX_MODULE) : w.module_req;
               exp_code = '0;
               if (m <= sars_pkg::MOD_LAST_SHARED) begin
                  sel_line = '0;
                  sel_port = sars_pkg::PORT_1;
               end else if (m <= sars_pkg::MOD_LAST_PORT1) begin
                  sel_line = 3'(m - 1);
                  sel_port = sars_pkg::PORT_1;
               end else if (m <= sars_pkg::MOD_LAST_PORT2) begin
                  sel_line = 3'(m - 1);
                  sel_port = sars_pkg::PORT_2;
               end else begin
                  sel_line = sars_pkg::EXP_LINE;
                  sel_port = sars_pkg::PORT_2;
                  exp_code = 3'(m - sars_pkg::MOD_FIRST_EXP);
               end
               chan_sr   = w.channel;
               sample_sr = '0;
               pin_count = '0;
               clk_lvl   = 1'b0;
               selected  = 1'b1;
               pin_phase = (m >= sars_pkg::MOD_FIRST_EXP) ? sars_pkg::PH_EXP_HI
                                                           : sars_pkg::PH_LEAD_HI;
            end
         end
      endcase
      lv.sclk            = clk_lvl;
      lv.sdo             = sdo_lvl;
      lv.select_line     = sel_line;
      lv.select_port     = sel_port;
      lv.select_asserted = selected;
      lv.busy_res        = (pin_phase != sars_pkg::PH_IDLE);
      lv.sample_valid    = done;
      lv.sample          = done ? sample_sr[11:0] : '0;
      return lv;
   endfunction

   // Queue one full read: a start, then just enough advances to finish it
   task automatic push_read(input logic [4:0] mod_num, input logic [4:0] chan,
                            input logic [15:0] sdi_bits, input bit stray_starts);
      sars_pkg::req_payload_type w;
      int              steps;
      w.command    = sars_pkg::CMD_START;
      w.module_req = mod_num;
      w.channel    = chan;
      w.sdi        = sdi_bits[15];
      pending_words.push_back(w);
      steps = 4 + 2 * DATA_BITS + 1;
      if (mod_num >= sars_pkg::MOD_FIRST_EXP)
         steps += 6;
      for (int i = 0; i < steps; i++) begin
         // a start while busy is only an advance
         w.command    = (stray_starts && $urandom_range(0, 9) == 0) ? sars_pkg::CMD_START
                                                                    : sars_pkg::CMD_ADVANCE;
         w.module_req = 5'($urandom);
         w.channel    = 5'($urandom);
         w.sdi        = sdi_bits[4'(i % 16)];
         pending_words.push_back(w);
      end
   endtask

   task automatic push_word(input logic cmd, input logic [4:0] mod_num,
                            input logic [4:0] chan, input logic sdi);
      sars_pkg::req_payload_type w;
      w.command    = cmd;
      w.module_req = mod_num;
      w.channel    = chan;
      w.sdi        = sdi;
      pending_words.push_back(w);
   endtask

   // Wait count per word, with occasional stretches of back-to-back words
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         err_count++;
      end
   endfunction

   // Request driver
   int send_wait = 0;
   int send_burst = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_levels.push_back(step_pins(req_data));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               send_wait = draw_wait(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   int              stall_left = 0;
   int              stall_burst = 0;
   sars_pkg::rsp_payload_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $error("response word with no request outstanding");
               err_count++;
            end else begin
               want = expected_levels.pop_front();
               check_field("sclk", 16'(want.sclk), 16'(rsp_data.sclk));
               check_field("sdo", 16'(want.sdo), 16'(rsp_data.sdo));
               check_field("select_line", 16'(want.select_line),
                           16'(rsp_data.select_line));
               check_field("select_port", 16'(want.select_port),
                           16'(rsp_data.select_port));
               check_field("select_asserted", 16'(want.select_asserted),
                           16'(rsp_data.select_asserted));
               check_field("busy_res", 16'(want.busy_res), 16'(rsp_data.busy_res));
               check_field("sample_valid", 16'(want.sample_valid),
                           16'(rsp_data.sample_valid));
               check_field("sample", 16'(want.sample), 16'(rsp_data.sample));
            end
            stall_left = draw_wait(stall_burst);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int r;
      logic [4:0] mod_num;
      clear_pin_state();

      // advance while idle, then saturated module with stray starts mid-read
      push_word(sars_pkg::CMD_ADVANCE, 5'h1F, 5'h1F, 1'b1);
      push_read(5'd31, 5'h1F, 16'hFFFF, 1'b1);
      push_read(5'd0, 5'h00, 16'h0000, 1'b0);
      push_read(5'd9, 5'h15, 16'hA5C3, 1'b0);
      push_read(5'd5, 5'h0A, 16'h5A3C, 1'b0);
      push_word(sars_pkg::CMD_ADVANCE, 5'h00, 5'h00, 1'b0);

      while (pending_words.size() < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r < 8) begin
            mod_num = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                  : 5'($urandom_range(0, 16));
            push_read(mod_num, 5'($urandom), 16'($urandom), $urandom_range(0, 2) == 0);
         end else if (r == 8) begin
            repeat ($urandom_range(1, 6))
               push_word(1'($urandom), 5'($urandom), 5'($urandom), 1'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               push_word(sars_pkg::CMD_ADVANCE, 5'($urandom), 5'($urandom),
                         1'($urandom));
         end
      end
      total_words = pending_words.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_words) @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_count == 0)
         $display("serial_adc_read_sequencer_tb: clean");
      else
         $display("serial_adc_read_sequencer_tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("serial_adc_read_sequencer_tb: errors");
      $finish;
   end

endmodule
